// ===== hw/rtl/decimal_text_to_int32_unit_macros.svh =====
// Assertion macros shared by the decimal text converter.
`ifndef DECIMAL_TEXT_TO_INT32_UNIT_MACROS_SVH
`define DECIMAL_TEXT_TO_INT32_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DTTI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtti: implication check failed");

// Next-cycle implication.
`define DTTI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtti: next-cycle check failed");

`else

`define DTTI_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTTI_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/dtti_pkg.sv =====
`default_nettype none

package dtti_pkg;

   localparam int VALUE_BITS = 32;
   localparam int OUT_W      = 32;
   localparam int CHAR_W     = 8;
   localparam int MAG_W      = VALUE_BITS;
   localparam int ACC_W      = VALUE_BITS + 4;

   localparam longint unsigned POS_LIMIT_L = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
   localparam longint unsigned NEG_LIMIT_L = POS_LIMIT_L + 64'd1;

   localparam logic [ACC_W-1:0] POS_LIMIT = ACC_W'(POS_LIMIT_L);
   localparam logic [ACC_W-1:0] NEG_LIMIT = ACC_W'(NEG_LIMIT_L);
   localparam logic [MAG_W-1:0] POS_QUOT  = MAG_W'(POS_LIMIT_L / 64'd10);
   localparam logic [MAG_W-1:0] NEG_QUOT  = MAG_W'(NEG_LIMIT_L / 64'd10);

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_BLANKS = 3'b001,
      PH_SIGN   = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

endpackage

`default_nettype wire

// ===== hw/rtl/decimal_text_to_int32_unit.sv =====
// Decimal text to signed 32-bit integer converter.
//
// req_ channel: one ASCII byte per transaction on req_char_code; a zero byte
// ends the string. Leading blanks and one sign are taken, then digits.
// rsp_ channel: one transaction per terminator, carrying rsp_value and
// rsp_error (value -1 with error set on overflow or a stray character).
// Other bytes produce no response.
//
// Timing: a byte is parsed from the input register into the state and the
// response register; a terminator shows on rsp_valid from the latter.
// Throughput: one byte per cycle while no terminator waits on a full
// response register; byte classification and the digit step (times ten,
// add, limit compare) are the logic between the input and state registers.
// Stall: the response register holds while rsp_ready is low; bytes other
// than a terminator keep flowing, a terminator waits in the input register
// and req_ready drops only then.
// Reset: synchronous, active high; empties both registers and returns the
// parser to the leading-blank state with a zero magnitude.
`default_nettype none
`include "decimal_text_to_int32_unit_macros.svh"

module decimal_text_to_int32_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [dtti_pkg::CHAR_W-1:0]      req_char_code,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [dtti_pkg::OUT_W-1:0]     rsp_value,
   output logic                                  rsp_error
);

   logic                            in_vld_ff, in_vld_in;
   logic [dtti_pkg::CHAR_W-1:0]     in_char_ff;

   dtti_pkg::phase_type             phase_ff, phase_in;
   logic                            neg_ff, neg_in;
   logic [dtti_pkg::MAG_W-1:0]      mag_ff, mag_in;
   logic                            failed_ff, failed_in;

   logic                            out_vld_ff, out_vld_in;
   logic signed [dtti_pkg::OUT_W-1:0] out_value_ff;
   logic                            out_error_ff;

   logic                            is_term, is_digit, is_blank, is_sign;
   logic                            out_free, proc_fire, emit;
   logic [dtti_pkg::MAG_W-1:0]      quot;
   logic [dtti_pkg::ACC_W-1:0]      limit, acc;
   logic [3:0]                      digit;
   logic [63:0]                     mag_wide, signed_wide;

   // classify the staged byte
   always_comb begin
      is_term  = 1'b0;
      is_digit = 1'b0;
      is_blank = 1'b0;
      is_sign  = 1'b0;
      case (in_char_ff) inside
         dtti_pkg::CHAR_NUL:                          is_term  = 1'b1;
         [dtti_pkg::CHAR_ZERO:dtti_pkg::CHAR_NINE]:   is_digit = 1'b1;
         dtti_pkg::CHAR_SPACE,
         [dtti_pkg::CHAR_TAB:dtti_pkg::CHAR_CR]:      is_blank = 1'b1;
         dtti_pkg::CHAR_PLUS, dtti_pkg::CHAR_MINUS:   is_sign  = 1'b1;
         default: ;
      endcase
   end

   assign out_free  = !out_vld_ff || rsp_ready;
   assign proc_fire = in_vld_ff && (!is_term || out_free);
   assign emit      = proc_fire && is_term;
   assign req_ready = !in_vld_ff || proc_fire;

   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !proc_fire);

   // digit step: times ten plus digit, checked against the signed range
   assign digit = 4'(in_char_ff - dtti_pkg::CHAR_ZERO);
   assign quot  = neg_ff ? dtti_pkg::NEG_QUOT  : dtti_pkg::POS_QUOT;
   assign limit = neg_ff ? dtti_pkg::NEG_LIMIT : dtti_pkg::POS_LIMIT;
   assign acc   = (dtti_pkg::ACC_W'(mag_ff) << 3) + (dtti_pkg::ACC_W'(mag_ff) << 1)
                  + dtti_pkg::ACC_W'(digit);

   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      failed_in = failed_ff;
      if (is_term) begin
         phase_in  = dtti_pkg::PH_BLANKS;
         neg_in    = 1'b0;
         mag_in    = '0;
         failed_in = 1'b0;
      end else if (!failed_ff) begin
         if (is_digit) begin
            phase_in = dtti_pkg::PH_DIGITS;
            if (mag_ff > quot) begin
               failed_in = 1'b1;
            end else begin
               mag_in = dtti_pkg::MAG_W'(acc);
               if (acc > limit) begin
                  failed_in = 1'b1;
               end
            end
         end else if (phase_ff == dtti_pkg::PH_BLANKS && is_blank) begin
            // hold in leading blanks
         end else if (phase_ff == dtti_pkg::PH_BLANKS && is_sign) begin
            neg_in   = (in_char_ff == dtti_pkg::CHAR_MINUS);
            phase_in = dtti_pkg::PH_SIGN;
         end else begin
            failed_in = 1'b1;
         end
      end
   end

   assign mag_wide    = 64'(mag_ff);
   assign signed_wide = neg_ff ? (64'd0 - mag_wide) : mag_wide;
   assign out_vld_in  = emit || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= dtti_pkg::PH_BLANKS;
         neg_ff     <= 1'b0;
         mag_ff     <= '0;
         failed_ff  <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (proc_fire) begin
            phase_ff  <= phase_in;
            neg_ff    <= neg_in;
            mag_ff    <= mag_in;
            failed_ff <= failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
      end
      if (emit) begin
         if (failed_ff) begin
            out_value_ff <= '1;
            out_error_ff <= 1'b1;
         end else begin
            out_value_ff <= signed_wide[dtti_pkg::OUT_W-1:0];
            out_error_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_value = out_value_ff;
   assign rsp_error = out_error_ff;

   `DTTI_ASSERT_IMP(a_error_value, clock, reset, out_vld_ff && out_error_ff, out_value_ff == '1)
   `DTTI_ASSERT_NXT(a_term_clears, clock, reset, emit,
                    phase_ff == dtti_pkg::PH_BLANKS && mag_ff == '0 && !failed_ff && !neg_ff)
   `DTTI_ASSERT_IMP(a_mag_bound, clock, reset, !failed_ff,
                    dtti_pkg::ACC_W'(mag_ff) <= dtti_pkg::NEG_LIMIT)
   `DTTI_ASSERT_NXT(a_stage_hold, clock, reset, in_vld_ff && !proc_fire,
                    in_vld_ff && $stable(in_char_ff))

endmodule

`default_nettype wire

// ===== tb/sv/tb_decimal_text_to_int32_unit.sv =====
`timescale 1ns / 100ps

module tb_decimal_text_to_int32_unit;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 345;
   localparam int N_ROWS         = 16;
   localparam logic [63:0] POS_MAX = 64'd2147483647;
   localparam logic [63:0] NEG_MAX = 64'd2147483648;

   typedef struct packed {
      logic signed [dtti_pkg::OUT_W-1:0] value;
      logic                              error;
   } conversion_type;

   typedef struct packed {
      bit             typed;
      conversion_type conv;
   } row_check_type;

   typedef struct {
      string text;
      bit    typed;
      int    value;
      bit    error;
   } text_row_type;

   typedef logic [dtti_pkg::CHAR_W-1:0] char_queue_type[$];

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [dtti_pkg::CHAR_W-1:0]       req_char_code = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic signed [dtti_pkg::OUT_W-1:0] rsp_value;
   logic                              rsp_error;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int items_sent    = 0;
   int failures      = 0;
   int quiet_cycles  = 0;

   // Shadow copy of the parser state
   dtti_pkg::phase_type parse_phase;
   logic                parse_negative;
   logic [63:0]         parse_magnitude;
   logic                parse_failed;

   conversion_type queued_conversions[$];
   row_check_type  table_checks[$];
   conversion_type new_conv;
   conversion_type want_conv;
   row_check_type  row_check;

   text_row_type text_rows[N_ROWS] = '{
      '{"",                        1, 0, 0},
      '{"\011\012\013\014\015 +",  1, 0, 0},
      '{"-",                       1, 0, 0},
      '{"2147483647",              1, 2147483647, 0},
      '{"-2147483648",             1, 32'sh8000_0000, 0},
      '{"+2147483648",             1, -1, 1},
      '{"-2147483649",             1, -1, 1},
      '{"99999999999",             1, -1, 1},
      '{"-007",                    0, 0, 0},
      '{"12 ",                     1, -1, 1},
      '{"+-5",                     1, -1, 1},
      '{"5a9",                     1, -1, 1},
      '{"/:",                      1, -1, 1},
      '{"\200\377",                1, -1, 1},
      '{"0",                       1, 0, 0},
      '{" +9",                     0, 0, 0}
   };

   decimal_text_to_int32_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_error     (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_parse();
      parse_phase     = dtti_pkg::PH_BLANKS;
      parse_negative  = 1'b0;
      parse_magnitude = '0;
      parse_failed    = 1'b0;
   endfunction

   function automatic void accumulate_digit(input logic [dtti_pkg::CHAR_W-1:0] c);
      logic [63:0] limit;
      limit = parse_negative ? NEG_MAX : POS_MAX;
      parse_phase = dtti_pkg::PH_DIGITS;
      // Check before the multiply so the magnitude never wraps
      if (parse_magnitude > limit / 10) begin
         parse_failed = 1'b1;
      end else begin
         parse_magnitude = parse_magnitude * 10 + 64'(c - dtti_pkg::CHAR_ZERO);
         if (parse_magnitude > limit)
            parse_failed = 1'b1;
      end
   endfunction

   // Advance the parser by one character; return 1 when a conversion completes.
   function automatic bit parse_char(input logic [dtti_pkg::CHAR_W-1:0] c,
                                     output conversion_type conv);
      logic [63:0] signed_mag;
      bit          is_digit;
      bit          is_blank;
      conv     = '0;
      is_digit = (c >= dtti_pkg::CHAR_ZERO) && (c <= dtti_pkg::CHAR_NINE);
      is_blank = (c == dtti_pkg::CHAR_SPACE) ||
                 ((c >= dtti_pkg::CHAR_TAB) && (c <= dtti_pkg::CHAR_CR));
      if (c == dtti_pkg::CHAR_NUL) begin
         if (parse_failed) begin
            conv.value = -1;
            conv.error = 1'b1;
         end else begin
            signed_mag = parse_negative ? (64'd0 - parse_magnitude) : parse_magnitude;
            conv.value = signed_mag[dtti_pkg::OUT_W-1:0];
            conv.error = 1'b0;
         end
         restart_parse();
         return 1'b1;
      end
      if (parse_failed)
         return 1'b0;
      if (parse_phase == dtti_pkg::PH_BLANKS) begin
         if (is_blank) begin
            // stay in the blank phase
         end else if (c == dtti_pkg::CHAR_MINUS || c == dtti_pkg::CHAR_PLUS) begin
            parse_negative = (c == dtti_pkg::CHAR_MINUS);
            parse_phase    = dtti_pkg::PH_SIGN;
         end else if (is_digit) begin
            accumulate_digit(c);
         end else begin
            parse_failed = 1'b1;
         end
      end else if (is_digit) begin
         accumulate_digit(c);
      end else begin
         parse_failed = 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void make_text(output char_queue_type txt);
      int                          kind;
      int                          n;
      int                          r;
      longint unsigned             mag;
      string                       digits;
      string                       alphabet;
      logic [dtti_pkg::CHAR_W-1:0] stray;
      txt      = {};
      alphabet = "0123456789+- \011";
      kind     = $urandom_range(99);
      if (kind < 70) begin
         n = $urandom_range(3);
         repeat (n) begin
            r = $urandom_range(5);
            txt.push_back(r == 5 ? dtti_pkg::CHAR_SPACE
                                 : dtti_pkg::CHAR_TAB + dtti_pkg::CHAR_W'(r));
         end
         r = $urandom_range(2);
         if (r == 1) txt.push_back(dtti_pkg::CHAR_PLUS);
         if (r == 2) txt.push_back(dtti_pkg::CHAR_MINUS);
         if ($urandom_range(19) != 0) begin
            case ($urandom_range(4))
               0: mag = $urandom_range(999);
               1: mag = $urandom();
               // straddle both limits
               2: mag = 64'd2147483638 + $urandom_range(20);
               3: mag = {$urandom(), $urandom()};
               default: mag = $urandom_range(99999);
            endcase
            if ($urandom_range(3) == 0) begin
               n = $urandom_range(1, 3);
               repeat (n) txt.push_back(dtti_pkg::CHAR_ZERO);
            end
            digits = $sformatf("%0d", mag);
            for (int i = 0; i < digits.len(); i++)
               txt.push_back(dtti_pkg::CHAR_W'(digits[i]));
         end
         if (kind >= 55) begin
            do
               stray = dtti_pkg::CHAR_W'($urandom_range(1, 255));
            while (stray >= dtti_pkg::CHAR_ZERO && stray <= dtti_pkg::CHAR_NINE);
            txt.insert($urandom_range(txt.size()), stray);
         end
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            if ($urandom_range(1))
               txt.push_back(dtti_pkg::CHAR_W'($urandom_range(255)));
            else
               txt.push_back(dtti_pkg::CHAR_W'(alphabet[$urandom_range(alphabet.len() - 1)]));
         end
      end
      txt.push_back(dtti_pkg::CHAR_NUL);
   endfunction

   task automatic send_char(input logic [dtti_pkg::CHAR_W-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset) begin
         restart_parse();
         quiet_cycles = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (parse_char(req_char_code, new_conv)) begin
               if (table_checks.size() > 0) begin
                  row_check = table_checks.pop_front();
                  if (row_check.typed)
                     new_conv = row_check.conv;
               end
               queued_conversions.push_back(new_conv);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (queued_conversions.size() == 0) begin
               $error("unexpected rsp transaction: value %0d error %0b", rsp_value, rsp_error);
               failures++;
            end else begin
               want_conv = queued_conversions.pop_front();
               if (rsp_value !== want_conv.value) begin
                  $error("rsp_value: expected %0d, actual %0d", want_conv.value, rsp_value);
                  failures++;
               end
               if (rsp_error !== want_conv.error) begin
                  $error("rsp_error: expected %0b, actual %0b", want_conv.error, rsp_error);
                  failures++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      char_queue_type txt;
      row_check_type  chk;
      int             target;
      int             idle_mix[4][2];
      idle_mix = '{'{0, 0}, '{60, 0}, '{0, 60}, '{29, 29}};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (text_rows[r]) begin
         chk.typed      = text_rows[r].typed;
         chk.conv.value = text_rows[r].value;
         chk.conv.error = text_rows[r].error;
         table_checks.push_back(chk);
         for (int i = 0; i < text_rows[r].text.len(); i++)
            send_char(dtti_pkg::CHAR_W'(text_rows[r].text[i]));
         send_char(dtti_pkg::CHAR_NUL);
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_mix[p][0];
         stall_pct    <= idle_mix[p][1];
         target        = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            make_text(txt);
            foreach (txt[i]) send_char(txt[i]);
         end
      end
      req_valid <= 1'b0;

      // let the last accepted byte reach the predictor before draining
      @(posedge clock);
      // drain outstanding conversions, then wait for strays
      while (queued_conversions.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0 && queued_conversions.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dtti_pkg.sv
hw/rtl/decimal_text_to_int32_unit.sv
tb/sv/tb_decimal_text_to_int32_unit.sv
